// File: design/line_segment_intersection_macros.svh
// ----------------------------------------------------------------------------
// line_segment_intersection_macros
// Assertion macros for the segment intersection RTL.
// ----------------------------------------------------------------------------
// Clock and reset names are those of the block: clock and reset.
`ifndef LINE_SEGMENT_INTERSECTION_MACROS_SVH
`define LINE_SEGMENT_INTERSECTION_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LSI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked during reset too
`define LSI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package lsi_pkg;

   // Control flags that travel with each word through the divider stages
   typedef struct packed {
      logic valid;
      logic hit;
      logic neg;
   } lsi_flags_type;

endpackage

// File: design/lsi_divider.sv
// ----------------------------------------------------------------------------
// lsi_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module lsi_divider
   import lsi_pkg::*;
#(
   parameter int MAG_BITS  = 34,
   parameter int QUOT_BITS = 24,
   parameter int SIDE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  lsi_flags_type        in_flags,
   input  logic [SIDE_BITS-1:0] in_side,
   input  logic [MAG_BITS-1:0]  in_divisor,
   input  logic [MAG_BITS-1:0]  in_top,
   input  logic [QUOT_BITS-1:0] in_low,
   output lsi_flags_type        out_flags,
   output logic [SIDE_BITS-1:0] out_side,
   output logic [QUOT_BITS-1:0] out_quot,
   output logic                 out_rem_nz
);

   lsi_flags_type        flags_ff [QUOT_BITS];
   logic [SIDE_BITS-1:0] side_ff  [QUOT_BITS];
   logic [MAG_BITS-1:0]  div_ff   [QUOT_BITS];
   logic [MAG_BITS-1:0]  rem_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0] low_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_ff  [QUOT_BITS];

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
      lsi_flags_type        prev_flags;
      logic [SIDE_BITS-1:0] prev_side;
      logic [MAG_BITS-1:0]  prev_div;
      logic [MAG_BITS-1:0]  prev_rem;
      logic [QUOT_BITS-1:0] prev_low;
      logic [QUOT_BITS-1:0] prev_quot;
      logic [MAG_BITS:0]    trial;
      logic                 take;
      logic [MAG_BITS-1:0]  rem_in;

      // pick up the previous stage, or the inputs at the head
      if (k == 0) begin : g_head
         assign prev_flags = in_flags;
         assign prev_side  = in_side;
         assign prev_div   = in_divisor;
         assign prev_rem   = in_top;
         assign prev_low   = in_low;
         assign prev_quot  = '0;
      end else begin : g_body
         assign prev_flags = flags_ff[k-1];
         assign prev_side  = side_ff[k-1];
         assign prev_div   = div_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_low   = low_ff[k-1];
         assign prev_quot  = quot_ff[k-1];
      end

      // bring down one dividend bit and subtract where it fits
      assign trial  = {prev_rem, prev_low[QUOT_BITS-1]};
      assign take   = (trial >= {1'b0, prev_div});
      assign rem_in = take ? MAG_BITS'(trial - {1'b0, prev_div}) : MAG_BITS'(trial);

      // advance the stage when the pipeline moves
      always_ff @(posedge clock) begin
         if (reset) begin
            flags_ff[k] <= '0;
         end else if (enable) begin
            flags_ff[k] <= prev_flags;
            side_ff[k]  <= prev_side;
            div_ff[k]   <= prev_div;
            rem_ff[k]   <= rem_in;
            low_ff[k]   <= prev_low << 1;
            quot_ff[k]  <= (prev_quot << 1) | QUOT_BITS'(take);
         end
      end
   end

   assign out_flags  = flags_ff[QUOT_BITS-1];
   assign out_side   = side_ff[QUOT_BITS-1];
   assign out_quot   = quot_ff[QUOT_BITS-1];
   assign out_rem_nz = (rem_ff[QUOT_BITS-1] != '0);

endmodule

// File: design/line_segment_intersection.sv
// ----------------------------------------------------------------------------
// line_segment_intersection
// Two-segment intersection test with fixed-point crossing point.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one word per test: the endpoints of segments A
//   and B as signed COORD_BITS integers. The rsp_ channel returns one word
//   per test: rsp_hit, and the crossing point in signed fixed point with
//   FRAC_BITS fraction bits (both coordinates zero without a hit).
//   A word is taken at a clock edge where valid is high and stall is low.
//   The word passes through these stages in order: five stages form
//   differences, products, the determinant and numerators, the range test
//   and the dividend products, then one stage per quotient bit in the
//   restoring dividers, then the output register.
//   Throughput is one word per cycle while the receiver does not stall; the quotient-bit stages set the depth.
//   Reset clears every valid bit; no word is in flight afterwards.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   req_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "line_segment_intersection_macros.svh"

module line_segment_intersection
   import lsi_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_ax_start,
   input  logic signed [COORD_BITS-1:0]          req_ay_start,
   input  logic signed [COORD_BITS-1:0]          req_ax_end,
   input  logic signed [COORD_BITS-1:0]          req_ay_end,
   input  logic signed [COORD_BITS-1:0]          req_bx_start,
   input  logic signed [COORD_BITS-1:0]          req_by_start,
   input  logic signed [COORD_BITS-1:0]          req_bx_end,
   input  logic signed [COORD_BITS-1:0]          req_by_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic signed [COORD_BITS+FRAC_BITS-1:0] rsp_cross_x,
   output logic signed [COORD_BITS+FRAC_BITS-1:0] rsp_cross_y
);

   localparam int CW = COORD_BITS;
   localparam int DW = COORD_BITS + 1;          // coordinate difference
   localparam int PW = 2 * DW;                  // products and determinant
   localparam int OW = COORD_BITS + FRAC_BITS;  // output and quotient width
   localparam int NW = PW + CW;                 // dividend product
   localparam int XW = NW + FRAC_BITS;          // scaled dividend
   localparam int EW = OW + 2;                  // crossing sum before wrap

   logic enable;

   // stage 1: differences
   logic                 v1_ff;
   logic signed [DW-1:0] dxa1_ff, dya1_ff, dxb1_ff, dyb1_ff, ox1_ff, oy1_ff;
   logic signed [CW-1:0] x1_1_ff, y1_1_ff;

   // stage 2: products
   logic                 v2_ff;
   logic signed [PW-1:0] pd1_ff, pd2_ff, pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic signed [DW-1:0] dxa2_ff, dya2_ff;
   logic signed [CW-1:0] x1_2_ff, y1_2_ff;

   // stage 3: determinant and numerators
   logic                 v3_ff;
   logic signed [PW-1:0] d3_ff, na3_ff, nb3_ff;
   logic signed [DW-1:0] dxa3_ff, dya3_ff;
   logic signed [CW-1:0] x1_3_ff, y1_3_ff;

   // stage 4: range test and magnitudes
   logic                 v4_ff, hit4_ff, negx4_ff, negy4_ff;
   logic [PW-1:0]        nam4_ff, dm4_ff;
   logic [CW-1:0]        dxam4_ff, dyam4_ff;
   logic signed [CW-1:0] x1_4_ff, y1_4_ff;
   logic                 hit4_in, negx4_in, negy4_in;
   logic [PW-1:0]        nam4_in, dm4_in;
   logic [CW-1:0]        dxam4_in, dyam4_in;

   // stage 5: dividend products
   logic                 v5_ff, hit5_ff, negx5_ff, negy5_ff;
   logic [NW-1:0]        prx5_ff, pry5_ff;
   logic [PW-1:0]        dm5_ff;
   logic signed [CW-1:0] x1_5_ff, y1_5_ff;

   // divider hookup
   logic [XW-1:0]        dvdx, dvdy;
   lsi_flags_type        flx_in, fly_in, flx_out, fly_out;
   logic [CW-1:0]        px_out, py_out;
   logic [OW-1:0]        qx_out, qy_out;
   logic                 rnzx_out, rnzy_out;

   // output stage
   logic                 rsp_valid_ff, rsp_hit_ff;
   logic [OW-1:0]        rsp_cross_x_ff, rsp_cross_y_ff;
   logic [OW-1:0]        cross_x_in, cross_y_in;

   // hold everything while a finished word is stalled
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff   <= req_valid;
         dxa1_ff <= DW'(req_ax_end) - DW'(req_ax_start);
         dya1_ff <= DW'(req_ay_end) - DW'(req_ay_start);
         dxb1_ff <= DW'(req_bx_end) - DW'(req_bx_start);
         dyb1_ff <= DW'(req_by_end) - DW'(req_by_start);
         ox1_ff  <= DW'(req_ax_start) - DW'(req_bx_start);
         oy1_ff  <= DW'(req_ay_start) - DW'(req_by_start);
         x1_1_ff <= req_ax_start;
         y1_1_ff <= req_ay_start;
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff   <= v1_ff;
         pd1_ff  <= PW'(dyb1_ff) * PW'(dxa1_ff);
         pd2_ff  <= PW'(dxb1_ff) * PW'(dya1_ff);
         pa1_ff  <= PW'(dxb1_ff) * PW'(oy1_ff);
         pa2_ff  <= PW'(dyb1_ff) * PW'(ox1_ff);
         pb1_ff  <= PW'(dxa1_ff) * PW'(oy1_ff);
         pb2_ff  <= PW'(dya1_ff) * PW'(ox1_ff);
         dxa2_ff <= dxa1_ff;
         dya2_ff <= dya1_ff;
         x1_2_ff <= x1_1_ff;
         y1_2_ff <= y1_1_ff;
      end
   end

   // stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff   <= v2_ff;
         d3_ff   <= pd1_ff - pd2_ff;
         na3_ff  <= pa1_ff - pa2_ff;
         nb3_ff  <= pb1_ff - pb2_ff;
         dxa3_ff <= dxa2_ff;
         dya3_ff <= dya2_ff;
         x1_3_ff <= x1_2_ff;
         y1_3_ff <= y1_2_ff;
      end
   end

   // stage 4: both parameters inside [0,1], signs and magnitudes
   always_comb begin
      logic ina, inb;
      if (d3_ff > 0) begin
         ina = (na3_ff >= 0) && (na3_ff <= d3_ff);
         inb = (nb3_ff >= 0) && (nb3_ff <= d3_ff);
      end else begin
         ina = (na3_ff <= 0) && (na3_ff >= d3_ff);
         inb = (nb3_ff <= 0) && (nb3_ff >= d3_ff);
      end
      hit4_in  = (d3_ff != '0) && ina && inb;
      negx4_in = na3_ff[PW-1] ^ dxa3_ff[DW-1] ^ d3_ff[PW-1];
      negy4_in = na3_ff[PW-1] ^ dya3_ff[DW-1] ^ d3_ff[PW-1];
      nam4_in  = na3_ff[PW-1] ? PW'(-na3_ff) : PW'(na3_ff);
      dm4_in   = d3_ff[PW-1] ? PW'(-d3_ff) : PW'(d3_ff);
      dxam4_in = dxa3_ff[DW-1] ? CW'(-dxa3_ff) : CW'(dxa3_ff);
      dyam4_in = dya3_ff[DW-1] ? CW'(-dya3_ff) : CW'(dya3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (enable) begin
         v4_ff    <= v3_ff;
         hit4_ff  <= hit4_in;
         negx4_ff <= negx4_in;
         negy4_ff <= negy4_in;
         nam4_ff  <= nam4_in;
         dm4_ff   <= dm4_in;
         dxam4_ff <= dxam4_in;
         dyam4_ff <= dyam4_in;
         x1_4_ff  <= x1_3_ff;
         y1_4_ff  <= y1_3_ff;
      end
   end

   // stage 5: numerator times coordinate span
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (enable) begin
         v5_ff    <= v4_ff;
         hit5_ff  <= hit4_ff;
         negx5_ff <= negx4_ff;
         negy5_ff <= negy4_ff;
         prx5_ff  <= NW'(nam4_ff) * NW'(dxam4_ff);
         pry5_ff  <= NW'(nam4_ff) * NW'(dyam4_ff);
         dm5_ff   <= dm4_ff;
         x1_5_ff  <= x1_4_ff;
         y1_5_ff  <= y1_4_ff;
      end
   end

   // scale the dividend and split it at the quotient width
   assign dvdx   = XW'(prx5_ff) << FRAC_BITS;
   assign dvdy   = XW'(pry5_ff) << FRAC_BITS;
   assign flx_in = '{valid: v5_ff, hit: hit5_ff, neg: negx5_ff};
   assign fly_in = '{valid: v5_ff, hit: hit5_ff, neg: negy5_ff};

   lsi_divider #(
      .MAG_BITS  (PW),
      .QUOT_BITS (OW),
      .SIDE_BITS (CW)
   ) u_div_x (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_flags   (flx_in),
      .in_side    (x1_5_ff),
      .in_divisor (dm5_ff),
      .in_top     (dvdx[XW-1:OW]),
      .in_low     (dvdx[OW-1:0]),
      .out_flags  (flx_out),
      .out_side   (px_out),
      .out_quot   (qx_out),
      .out_rem_nz (rnzx_out)
   );

   lsi_divider #(
      .MAG_BITS  (PW),
      .QUOT_BITS (OW),
      .SIDE_BITS (CW)
   ) u_div_y (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_flags   (fly_in),
      .in_side    (y1_5_ff),
      .in_divisor (dm5_ff),
      .in_top     (dvdy[XW-1:OW]),
      .in_low     (dvdy[OW-1:0]),
      .out_flags  (fly_out),
      .out_side   (py_out),
      .out_quot   (qy_out),
      .out_rem_nz (rnzy_out)
   );

   // add the scaled start point and round the sum toward zero
   function automatic logic [OW-1:0] lsi_cross(
      input logic [CW-1:0] p,
      input logic [OW-1:0] q,
      input logic          neg,
      input logic          rnz,
      input logic          hit
   );
      logic signed [EW-1:0] base;
      logic signed [EW-1:0] qs;
      base = EW'($signed(p)) <<< FRAC_BITS;
      qs   = $signed({2'b00, q});
      base = neg ? base - qs : base + qs;
      if (rnz && !neg && base < 0) begin
         base = base + EW'(1);
      end else if (rnz && neg && base > 0) begin
         base = base - EW'(1);
      end
      return hit ? OW'(base) : '0;
   endfunction

   assign cross_x_in = lsi_cross(px_out, qx_out, flx_out.neg, rnzx_out, flx_out.hit);
   assign cross_y_in = lsi_cross(py_out, qy_out, fly_out.neg, rnzy_out, fly_out.hit);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff   <= flx_out.valid;
         rsp_hit_ff     <= flx_out.hit;
         rsp_cross_x_ff <= cross_x_in;
         rsp_cross_y_ff <= cross_y_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_cross_x = rsp_cross_x_ff;
   assign rsp_cross_y = rsp_cross_y_ff;

   `LSI_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp_hit, rsp_cross_x == '0 && rsp_cross_y == '0, "crossing point not zero on a miss")
   `LSI_ASSERT_IMP(a_lanes_valid, 1'b1, flx_out.valid == fly_out.valid, "divider lane valid bits differ")
   `LSI_ASSERT_IMP(a_lanes_hit, flx_out.valid, flx_out.hit == fly_out.hit, "divider lane hit flags differ")
   `LSI_ASSERT_NEXT(a_reset_empty, reset, !rsp_valid, "result valid straight after reset")

endmodule

// File: tb/line_segment_intersection_checker.sv
// ----------------------------------------------------------------------------
// line_segment_intersection_checker
// Watches both channels of the segment intersection block, predicts each
// result from the accepted request word and compares it field by field.
// ----------------------------------------------------------------------------
module line_segment_intersection_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic signed [15:0]  req_ax_start,
   input  logic signed [15:0]  req_ay_start,
   input  logic signed [15:0]  req_ax_end,
   input  logic signed [15:0]  req_ay_end,
   input  logic signed [15:0]  req_bx_start,
   input  logic signed [15:0]  req_by_start,
   input  logic signed [15:0]  req_bx_end,
   input  logic signed [15:0]  req_by_end,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_hit,
   input  logic signed [23:0]  rsp_cross_x,
   input  logic signed [23:0]  rsp_cross_y,
   output int                  fail_count,
   output int                  crossings_pending,
   output int                  hit_count
);

   typedef struct {
      logic               hit;
      logic signed [23:0] cross_x;
      logic signed [23:0] cross_y;
   } crossing_type;

   crossing_type crossing_queue[$];

   // Scale p + n*dp/d by 256, truncated toward zero
   function automatic logic signed [23:0] scale_point(longint p, longint dp,
                                                     longint n, longint d);
      bit     neg;
      longint num, den, quo, rem, base;
      neg  = ((n < 0) != (dp < 0)) != (d < 0);
      num  = (n < 0 ? -n : n) * (dp < 0 ? -dp : dp) * 256;
      den  = d < 0 ? -d : d;
      quo  = num / den;
      rem  = num % den;
      base = p * 256;
      base = neg ? base - quo : base + quo;
      if (rem != 0) begin
         if (!neg && base < 0)
            base++;
         else if (neg && base > 0)
            base--;
      end
      return base[23:0];
   endfunction

   function automatic bit in_unit(longint n, longint d);
      if (d > 0)
         return n >= 0 && n <= d;
      return n <= 0 && n >= d;
   endfunction

   function automatic crossing_type predict_crossing(
      longint x1, longint y1, longint x2, longint y2,
      longint x3, longint y3, longint x4, longint y4);
      crossing_type res;
      longint dxa, dya, dxb, dyb, ox, oy, d, na, nb;
      dxa = x2 - x1; dya = y2 - y1;
      dxb = x4 - x3; dyb = y4 - y3;
      ox  = x1 - x3; oy  = y1 - y3;
      d   = dyb * dxa - dxb * dya;
      na  = dxb * oy - dyb * ox;
      nb  = dxa * oy - dya * ox;
      res.hit = 0; res.cross_x = '0; res.cross_y = '0;
      if (d != 0 && in_unit(na, d) && in_unit(nb, d)) begin
         res.hit     = 1;
         res.cross_x = scale_point(x1, dxa, na, d);
         res.cross_y = scale_point(y1, dya, na, d);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // Queue a prediction per accepted request, compare each accepted response
   always @(posedge clock) begin
      crossing_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            crossing_queue.push_back(predict_crossing(
               req_ax_start, req_ay_start, req_ax_end, req_ay_end,
               req_bx_start, req_by_start, req_bx_end, req_by_end));
         if (rsp_valid && !rsp_stall) begin
            if (crossing_queue.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = crossing_queue.pop_front();
               if (want.hit)
                  hit_count++;
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_cross_x !== want.cross_x)
                  report_mismatch("cross_x", rsp_cross_x, want.cross_x);
               if (rsp_cross_y !== want.cross_y)
                  report_mismatch("cross_y", rsp_cross_y, want.cross_y);
            end
         end
      end
      crossings_pending = crossing_queue.size();
   end

endmodule

// File: tb/tb_line_segment_intersection.sv
// ----------------------------------------------------------------------------
// tb_line_segment_intersection
// Directed and random segment pairs through the intersection block, with
// random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_line_segment_intersection;

   localparam int RANDOM_WORDS = 1830;
   localparam int IDLE_LIMIT   = 5000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_ax_start, req_ay_start, req_ax_end, req_ay_end;
   logic signed [15:0] req_bx_start, req_by_start, req_bx_end, req_by_end;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_hit;
   logic signed [23:0] rsp_cross_x, rsp_cross_y;
   int                 fail_count, crossings_pending, hit_count;
   int                 words_sent;
   int                 idle_cycles;
   bit                 stimulus_done;

   line_segment_intersection u_top (.*);

   line_segment_intersection_checker u_checker (.*);

   // Clock and reset
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   // Offer one word and hold it until taken; the first coordinate listed
   // sits in the top slice of the packed word
   task automatic offer_segments(input logic [7:0][15:0] c, input bit may_idle);
      while (may_idle && $urandom_range(99) < 13) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid    = 1;
      req_ax_start = c[7]; req_ay_start = c[6];
      req_ax_end   = c[5]; req_ay_end   = c[4];
      req_bx_start = c[3]; req_by_start = c[2];
      req_bx_end   = c[1]; req_by_end   = c[0];
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] any_coord();
      case ($urandom_range(3))
         0: return 16'(16'h8000 + $urandom_range(3));
         1: return 16'(16'h7fff - $urandom_range(3));
         default: return 16'($urandom);
      endcase
   endfunction

   // Two segments that usually cross: A runs through one diagonal, B the other
   function automatic logic [7:0][15:0] crossing_pair(int span);
      logic [7:0][15:0] c;
      int cx, cy;
      cx = int'($urandom_range(2 * span)) - span;
      cy = int'($urandom_range(2 * span)) - span;
      c[0] = 16'(cx - int'($urandom_range(span)));
      c[1] = 16'(cy - int'($urandom_range(span)));
      c[2] = 16'(cx + int'($urandom_range(span)));
      c[3] = 16'(cy + int'($urandom_range(span)));
      c[4] = 16'(cx - int'($urandom_range(span)));
      c[5] = 16'(cy + int'($urandom_range(span)));
      c[6] = 16'(cx + int'($urandom_range(span)));
      c[7] = 16'(cy - int'($urandom_range(span)));
      return c;
   endfunction

   // Stimulus
   initial begin
      logic [7:0][15:0] c;
      int span;
      req_valid = 0; words_sent = 0; stimulus_done = 0;
      {req_ax_start, req_ay_start, req_ax_end, req_ay_end} = '0;
      {req_bx_start, req_by_start, req_bx_end, req_by_end} = '0;
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed: plain crossing, endpoint touches, parallel, collinear,
      // zero-length, disjoint, and the coordinate extremes
      offer_segments({16'd10, -16'sd10, 16'd10, 16'd10, 16'd0, 16'd0, 16'd0, 16'd0}, 0);
      offer_segments({16'd1, 16'd1, -16'sd1, -16'sd1, 16'd1, -16'sd1, -16'sd1, 16'd1}, 0);
      offer_segments({16'd3, 16'd0, 16'd0, 16'd7, 16'd0, 16'd0, 16'd0, 16'd0}, 0);
      offer_segments({16'd5, 16'd5, 16'd10, 16'd5, 16'd5, 16'd0, 16'd0, 16'd0}, 0);
      offer_segments({16'd0, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5, 16'd0}, 0);
      offer_segments({16'd0, 16'd1, 16'd5, 16'd1, 16'd0, 16'd0, 16'd5, 16'd0}, 0);
      offer_segments({16'd0, 16'd0, 16'd5, 16'd5, 16'd0, 16'd0, 16'd5, 16'd5}, 0);
      offer_segments({16'd0, 16'd0, 16'd5, 16'd5, 16'd3, 16'd3, 16'd8, 16'd8}, 0);
      offer_segments({16'd2, 16'd2, 16'd2, 16'd2, 16'd0, 16'd0, 16'd4, 16'd4}, 0);
      offer_segments({16'd0, 16'd0, 16'd1, 16'd1, 16'd5, 16'd0, 16'd4, 16'd1}, 0);
      offer_segments({16'd0, 16'd0, 16'd3, 16'd1, 16'd0, 16'd1, 16'd3, 16'd0}, 0);
      offer_segments({-16'sd7, 16'd0, 16'd0, -16'sd3, -16'sd7, -16'sd3, 16'd0, 16'd0}, 0);
      offer_segments({16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                      16'h8000, 16'h7fff, 16'h7fff, 16'h8000}, 0);
      offer_segments({16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                      16'h7fff, 16'h7fff, 16'h8000, 16'h8000}, 0);
      offer_segments({16'h8000, 16'h8000, 16'h8000, 16'h7fff,
                      16'h8000, 16'h0000, 16'h7fff, 16'h0000}, 0);
      offer_segments({16'h7fff, 16'h8000, 16'h8001, 16'h7ffe,
                      16'h8000, 16'h8000, 16'h7fff, 16'h7fff}, 0);
      offer_segments({16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 16'h8000, 16'h8000, 16'h8000}, 0);
      offer_segments({16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'hffff, 16'hffff, 16'hffff, 16'hffff}, 0);
      offer_segments({16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                      16'h0000, 16'h0001, 16'h0001, 16'h0000}, 0);
      offer_segments({16'd0, 16'd0, 16'd3, 16'd7, 16'd3, 16'd0, 16'd0, 16'd7}, 0);

      // Random: mostly crossing pairs of mixed spans, rest wide noise
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         case ($urandom_range(9))
            0, 1: c = {any_coord(), any_coord(), any_coord(), any_coord(),
                       any_coord(), any_coord(), any_coord(), any_coord()};
            2: begin
               c = {$urandom, $urandom, $urandom, $urandom};
            end
            default: begin
               case ($urandom_range(2))
                  0: span = 20;
                  1: span = 2000;
                  default: span = 16000;
               endcase
               c = crossing_pair(span);
            end
         endcase
         offer_segments(c, !(i >= 600 && i < 900));
      end
      req_valid     = 0;
      stimulus_done = 1;
   end

   // Receiver: random stalls, one long hold-off, one stretch with none
   initial begin
      int cyc;
      rsp_stall = 0;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc >= 1500 && cyc < 1800)
            rsp_stall = 1;
         else if (cyc >= 2500 && cyc < 2900)
            rsp_stall = 0;
         else
            rsp_stall = $urandom_range(99) < 13;
      end
   end

   // Watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("FAIL line_segment_intersection");
         $finish;
      end
   end

   // Drain and verdict
   initial begin
      wait (stimulus_done);
      while (crossings_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d segment pairs, %0d of them crossing, with idling",
               words_sent, hit_count);
      $display("on both sides and a long receiver hold-off; %0d mismatches",
               fail_count);
      if (fail_count == 0 && crossings_pending == 0)
         $display("PASS line_segment_intersection");
      else
         $display("FAIL line_segment_intersection");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/lsi_pkg.sv
design/lsi_divider.sv
design/line_segment_intersection.sv
tb/line_segment_intersection_checker.sv
tb/tb_line_segment_intersection.sv
